@@ hdl/pcx_rle_palette_texture_decoder_defines.svh @@
// Assertion macros used by the PCX decoder RTL
`ifndef PCX_RLE_PALETTE_TEXTURE_DECODER_DEFINES_SVH
`define PCX_RLE_PALETTE_TEXTURE_DECODER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define PCX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/pcx_pkg.sv @@
// Types and constants of the PCX run-length palette decoder
package pcx_pkg;

  localparam int unsigned TEX_SIZE        = 256;
  localparam int unsigned PALETTE_ENTRIES = 256;

  localparam logic [1:0] REQ_PAL_WRITE = 2'd0;
  localparam logic [1:0] REQ_BYTE      = 2'd1;
  localparam logic [1:0] REQ_START     = 2'd2;

  localparam logic [7:0] RUN_MARK     = 8'hC0;
  localparam logic [7:0] RUN_COUNT    = 8'h3F;
  localparam logic [7:0] OPAQUE_INDEX = 8'hFF;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  localparam logic       ADDR_BPL    = 1'b0;
  localparam logic       ADDR_HEIGHT = 1'b1;

  localparam logic [15:0] BPL_RESET    = 16'd256;
  localparam logic [15:0] HEIGHT_RESET = 16'd256;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] palette_index;
    logic [7:0] palette_red;
    logic [7:0] palette_green;
    logic [7:0] palette_blue;
    logic [7:0] code_byte;
  } pcx_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] texel_x;
    logic [7:0] texel_y;
    logic       last_of_run;
  } pcx_out_t;

  // sequencer to output stage: a palette read issued, or end of an input
  typedef struct packed {
    logic       texel;
    logic       flush;
    logic       opaque;
    logic [7:0] x;
    logic [7:0] y;
  } pcx_evt_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_RUN,
    SEQ_FLUSH
  } pcx_state_t;

endpackage

@@ hdl/pcx_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read
module pcx_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/pcx_seq.sv @@
// Run-length sequencer: stream parsing, scan position and palette access
module pcx_seq
  import pcx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  pcx_in_t     in_data,
  output logic        in_stall,
  input  logic [15:0] bytes_per_line,
  input  logic [15:0] image_height,
  input  logic        step_ok,
  output pcx_evt_t    evt,
  output logic        ram_we,
  output logic [7:0]  ram_waddr,
  output logic [23:0] ram_wdata,
  output logic        ram_re,
  output logic [7:0]  ram_raddr
);

  pcx_state_t  state_r, state_nxt;
  logic        awaiting_r, awaiting_nxt;
  logic [5:0]  runlen_r, runlen_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;

  logic        accept;
  logic        is_mark;
  logic        step;
  logic        in_img;
  logic        emit;
  logic [16:0] col_inc;
  logic        wrap;

  assign accept  = in_valid && !in_stall;
  assign is_mark = (in_data.code_byte & RUN_MARK) == RUN_MARK;
  assign step    = (state_r == SEQ_RUN) && step_ok;
  assign in_img  = row_r < image_height;
  assign emit    = in_img && (col_r < 16'(TEX_SIZE)) && (row_r < 16'(TEX_SIZE));
  assign col_inc = {1'b0, col_r} + 17'd1;
  assign wrap    = col_inc >= {1'b0, bytes_per_line};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SEQ_IDLE: begin
        if (accept && in_data.req_type == REQ_BYTE) begin
          if (awaiting_r) begin
            if (runlen_r != 6'd0) state_nxt = SEQ_RUN;
          end else if (!is_mark) begin
            state_nxt = SEQ_RUN;
          end
        end
      end
      SEQ_RUN: begin
        if (step_ok && cnt_r == 6'd1) state_nxt = SEQ_FLUSH;
      end
      SEQ_FLUSH: begin
        if (step_ok) state_nxt = SEQ_IDLE;
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  always_comb begin
    awaiting_nxt = awaiting_r;
    runlen_nxt   = runlen_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    if (accept) begin
      case (in_data.req_type)
        REQ_START: begin
          awaiting_nxt = 1'b0;
          runlen_nxt   = 6'd0;
          col_nxt      = 16'd0;
          row_nxt      = 16'd0;
        end
        REQ_BYTE: begin
          if (awaiting_r) begin
            awaiting_nxt = 1'b0;
            runlen_nxt   = 6'd0;
            cnt_nxt      = runlen_r;
            idx_nxt      = in_data.code_byte;
          end else if (is_mark) begin
            awaiting_nxt = 1'b1;
            runlen_nxt   = in_data.code_byte[5:0] & RUN_COUNT[5:0];
          end else begin
            cnt_nxt = 6'd1;
            idx_nxt = in_data.code_byte;
          end
        end
        default: ;
      endcase
    end
    if (step) begin
      cnt_nxt = cnt_r - 6'd1;
      if (in_img) begin
        if (wrap) begin
          col_nxt = 16'd0;
          row_nxt = row_r + 16'd1;
        end else begin
          col_nxt = col_inc[15:0];
        end
      end
    end
  end

  always_comb begin
    in_stall   = !rst_n || (state_r != SEQ_IDLE);
    evt.texel  = step && emit;
    evt.flush  = (state_r == SEQ_FLUSH) && step_ok;
    evt.opaque = idx_r == OPAQUE_INDEX;
    evt.x      = col_r[7:0];
    evt.y      = row_r[7:0];
    ram_re     = step && emit;
    ram_raddr  = idx_r;
    ram_we     = accept && (in_data.req_type == REQ_PAL_WRITE);
    ram_waddr  = in_data.palette_index;
    ram_wdata  = {in_data.palette_red, in_data.palette_green, in_data.palette_blue};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= SEQ_IDLE;
      awaiting_r <= 1'b0;
      runlen_r   <= 6'd0;
      cnt_r      <= 6'd0;
      col_r      <= 16'd0;
      row_r      <= 16'd0;
    end else begin
      state_r    <= state_nxt;
      awaiting_r <= awaiting_nxt;
      runlen_r   <= runlen_nxt;
      cnt_r      <= cnt_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

endmodule

@@ hdl/pcx_out.sv @@
// Output stage: palette read return, one-texel hold for last flag, output register
`include "pcx_rle_palette_texture_decoder_defines.svh"
module pcx_out
  import pcx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  pcx_evt_t    evt,
  input  logic [23:0] rgb,
  output logic        step_ok,
  output logic        out_valid,
  output pcx_out_t    out_data,
  input  logic        out_stall
);

  logic     a_vld_r, a_vld_nxt;
  pcx_evt_t a_r, a_nxt;
  logic     h_vld_r, h_vld_nxt;
  pcx_out_t h_r, h_nxt;
  logic     o_vld_r, o_vld_nxt;
  pcx_out_t o_r, o_nxt;

  logic     o_free;
  logic     a_move;
  logic     o_load;
  pcx_out_t a_texel;

  assign o_free  = !o_vld_r || !out_stall;
  assign a_move  = a_vld_r && (!h_vld_r || o_free);
  assign step_ok = !a_vld_r || a_move;
  assign o_load  = a_move && h_vld_r;

  always_comb begin
    a_texel.red         = rgb[23:16];
    a_texel.green       = rgb[15:8];
    a_texel.blue        = rgb[7:0];
    a_texel.alpha       = a_r.opaque ? ALPHA_OPAQUE : ALPHA_CLEAR;
    a_texel.texel_x     = a_r.x;
    a_texel.texel_y     = a_r.y;
    a_texel.last_of_run = 1'b0;
  end

  always_comb begin
    a_vld_nxt = a_vld_r;
    a_nxt     = a_r;
    h_vld_nxt = h_vld_r;
    h_nxt     = h_r;
    o_nxt     = o_r;
    if (step_ok) begin
      a_vld_nxt = evt.texel || evt.flush;
      a_nxt     = evt;
    end
    if (o_load) begin
      o_nxt             = h_r;
      o_nxt.last_of_run = a_r.flush;
    end
    if (a_move) begin
      if (a_r.texel) begin
        h_vld_nxt = 1'b1;
        h_nxt     = a_texel;
      end else begin
        h_vld_nxt = 1'b0;
      end
    end
    if (o_load) begin
      o_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      o_vld_nxt = 1'b0;
    end else begin
      o_vld_nxt = o_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      h_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      a_vld_r <= a_vld_nxt;
      h_vld_r <= h_vld_nxt;
      o_vld_r <= o_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    h_r <= h_nxt;
    o_r <= o_nxt;
  end

  assign out_valid = o_vld_r;
  assign out_data  = o_r;

  `PCX_ASSERT_IMP(a_one_kind, a_vld_r, !(a_r.texel && a_r.flush), "texel and flush in one beat")
  `PCX_ASSERT_NXT(a_held, a_vld_r && h_vld_r && !o_free, a_vld_r && $stable(a_r), "read return lost")
  `PCX_ASSERT_NXT(flush_empties, a_move && a_r.flush, !h_vld_r, "hold not emptied at end")
  `PCX_ASSERT_NXT(last_on_flush, o_load && a_r.flush, o_vld_r && o_r.last_of_run, "last flag missing")

endmodule

@@ hdl/pcx_rle_palette_texture_decoder.sv @@
// Top level: PCX run-length stream to palette RGBA texels
// Palette writes, starts, run headers and zero-count value bytes are accepted without leaving idle.
// A literal or a run value byte is accepted, then stepped once per position on the
// sequencer, then closed by a flush beat that ends the beat train; output stalls hold the steps.
// A texel passes the palette RAM read, the hold stage and the output register in turn.
// Sync active-low reset clears control state only.
module pcx_rle_palette_texture_decoder
  import pcx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  pcx_in_t     in_data,
  output logic        in_stall,
  output logic        out_valid,
  output pcx_out_t    out_data,
  input  logic        out_stall,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] bpl_r, bpl_nxt;
  logic [15:0] height_r, height_nxt;
  logic        cfg_wr;

  pcx_evt_t    evt;
  logic        step_ok;
  logic        ram_we;
  logic [7:0]  ram_waddr;
  logic [23:0] ram_wdata;
  logic        ram_re;
  logic [7:0]  ram_raddr;
  logic [23:0] ram_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    bpl_nxt    = bpl_r;
    height_nxt = height_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        ADDR_BPL:    bpl_nxt    = pwdata[15:0];
        ADDR_HEIGHT: height_nxt = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ADDR_BPL:    prdata = {16'd0, bpl_r};
      ADDR_HEIGHT: prdata = {16'd0, height_r};
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpl_r    <= BPL_RESET;
      height_r <= HEIGHT_RESET;
    end else begin
      bpl_r    <= bpl_nxt;
      height_r <= height_nxt;
    end
  end

  pcx_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_data        (in_data),
    .in_stall       (in_stall),
    .bytes_per_line (bpl_r),
    .image_height   (height_r),
    .step_ok        (step_ok),
    .evt            (evt),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr)
  );

  pcx_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pcx_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt       (evt),
    .rgb       (ram_rdata),
    .step_ok   (step_ok),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule
